/* hdl/carpid_pkg.sv */
`timescale 1ns / 1ps

package carpid_pkg;

   localparam int GAIN_BITS_DEF = 20;
   localparam int NUM_AXES_DEF  = 3;
   localparam int GAIN_SLOT     = 20;
   localparam int FRAC_BITS     = 12;
   localparam int PROD_W        = 48;
   localparam int CNT_W         = 5;

   localparam int CSR_W         = 60;
   localparam int CSR_IDX_W     = 3;

   localparam logic [CSR_IDX_W-1:0] REG_ROLL_GAINS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_GAINS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_YAW_GAINS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_LIMITS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_LIMITS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INT_LIMIT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_GAIN   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DTERM_ALPHA  = 3'd7;

   localparam logic [1:0] AXIS_ROLL  = 2'd0;
   localparam logic [1:0] AXIS_PITCH = 2'd1;
   localparam logic [1:0] AXIS_YAW   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MUL  = 3'b010,
      ST_POST = 3'b100
   } state_type;

   typedef enum logic [6:0] {
      PH_SP1  = 7'b0000001,
      PH_SP2  = 7'b0000010,
      PH_P    = 7'b0000100,
      PH_I    = 7'b0001000,
      PH_D    = 7'b0010000,
      PH_F    = 7'b0100000,
      PH_ZERO = 7'b1000000
   } phase_type;

endpackage

/* hdl/cascaded_attitude_rate_pid_core.sv */
`timescale 1ns / 1ps
// one request at a time, set by the shared bit-serial multiplier that takes one
//   multiplier bit per cycle; angle mode runs an extra multiply pass, an axis code of 3
//   skips the multiplier, and a stalled earlier result holds the output register
// throughput: the next request is taken once the result is in the output register
// reset: synchronous active high, clears control, config to defaults and all axis state
module cascaded_attitude_rate_pid_core
   import carpid_pkg::*;
#(
   parameter int GAIN_BITS = GAIN_BITS_DEF,
   parameter int NUM_AXES  = NUM_AXES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // config write port
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_axis,
   input  logic                 req_angle_mode,
   input  logic                 req_throttle_zero,
   input  logic signed [15:0]   req_stick_position,
   input  logic signed [15:0]   req_gyro_rate,
   input  logic signed [15:0]   req_attitude_angle,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_axis_out,
   output logic signed [17:0]   rsp_control_sum,
   output logic signed [17:0]   rsp_p_term,
   output logic signed [15:0]   rsp_i_term,
   output logic signed [17:0]   rsp_d_term,
   output logic signed [17:0]   rsp_rate_target
);

   // multiplier operand width covers gains and 16-bit limits / alpha
   localparam int MUL_W = (GAIN_BITS > 16) ? GAIN_BITS : 16;
   localparam int AX_W  = $clog2(NUM_AXES);

   // saturation bounds in product width
   localparam logic signed [PROD_W-1:0] MAX18 = PROD_W'(131071);
   localparam logic signed [PROD_W-1:0] MIN18 = -PROD_W'(131072);
   localparam logic signed [PROD_W-1:0] MAX24 = PROD_W'(8388607);
   localparam logic signed [PROD_W-1:0] MIN24 = -PROD_W'(8388608);

   function automatic logic signed [17:0] sat18(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] r;
      begin
         r = v;
         if (v > MAX18) r = MAX18;
         if (v < MIN18) r = MIN18;
         sat18 = r[17:0];
      end
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] r;
      begin
         r = v;
         if (v > MAX24) r = MAX24;
         if (v < MIN24) r = MIN24;
         sat24 = r[23:0];
      end
   endfunction

   // configuration registers
   logic [CSR_W-1:0] gains_ff [NUM_AXES];
   logic [47:0]      rate_limits_ff;
   logic [15:0]      angle_limits_ff;
   logic [14:0]      int_limit_ff;
   logic [7:0]       angle_gain_ff;
   logic [15:0]      alpha_ff;

   // per-axis controller state
   logic signed [31:0] istore_ff [NUM_AXES];
   logic signed [17:0] prev_ff   [NUM_AXES];
   logic signed [23:0] filt_ff   [NUM_AXES];

   // sequencer and working registers
   state_type          state_ff;
   phase_type          phase_ff;
   logic [1:0]         axis_ff;
   logic               angle_ff;
   logic signed [15:0] gyro_ff;
   logic signed [15:0] att_ff;
   logic signed [17:0] sp_ff;
   logic signed [17:0] err_ff;
   logic signed [17:0] p_ff;
   logic signed [15:0] i_ff;

   // bit-serial multiplier: multiplier bits shift out lsb first
   logic signed [PROD_W-1:0] mcand_ff;
   logic [MUL_W-1:0]         mult_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic rsp_valid_ff;

   logic                     req_accept;
   logic                     out_free;
   logic                     result_done;
   logic [AX_W-1:0]          ax;
   logic [CSR_W-1:0]         gain_sel;
   logic [MUL_W-1:0]         kp_w, ki_w, kd_w;
   logic [15:0]              rlim_in;
   logic [7:0]               alim_in;
   logic                     angle_in;
   logic signed [PROD_W-1:0] diff_in;
   logic signed [17:0]       sp_in;
   logic signed [17:0]       err_in;
   logic signed [17:0]       p_in;
   logic signed [PROD_W-1:0] lim_in;
   logic signed [PROD_W-1:0] iacc_in;
   logic signed [PROD_W-1:0] ediff_in;
   logic signed [23:0]       raw_in;
   logic signed [PROD_W-1:0] fdiff_in;
   logic signed [23:0]       filt_in;
   logic signed [17:0]       d_in;
   logic signed [17:0]       sum_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   // a new result enters the output register this cycle
   assign result_done = (state_ff == ST_POST) && out_free &&
                        (phase_ff == PH_F || phase_ff == PH_ZERO);

   // axis code 3 never reaches the state arrays; keep the index in range anyway
   assign ax = (axis_ff == AXIS_ROLL) ? AX_W'(0) :
               (axis_ff == AXIS_PITCH) ? AX_W'(1) : AX_W'(2);

   assign gain_sel = gains_ff[ax];
   assign kp_w = MUL_W'(gain_sel[GAIN_BITS-1:0]);
   assign ki_w = MUL_W'(gain_sel[GAIN_SLOT +: GAIN_BITS]);
   assign kd_w = MUL_W'(gain_sel[2*GAIN_SLOT +: GAIN_BITS]);

   // setpoint operands picked at request time
   always_comb begin
      case (req_axis)
         AXIS_ROLL:  rlim_in = rate_limits_ff[15:0];
         AXIS_PITCH: rlim_in = rate_limits_ff[31:16];
         default:    rlim_in = rate_limits_ff[47:32];
      endcase
      alim_in  = (req_axis == AXIS_ROLL) ? angle_limits_ff[7:0] : angle_limits_ff[15:8];
      // yaw always flies in rate mode
      angle_in = req_angle_mode && (req_axis == AXIS_ROLL || req_axis == AXIS_PITCH);
   end

   // post-multiply arithmetic for each phase
   always_comb begin
      diff_in = (prod_ff >>> 9) - PROD_W'(att_ff);
      if (phase_ff == PH_SP2) sp_in = sat18(prod_ff >>> 2);
      else                    sp_in = 18'(prod_ff >>> 15);
      err_in   = sat18(PROD_W'(sp_in) - PROD_W'(gyro_ff));
      p_in     = sat18(prod_ff >>> FRAC_BITS);
      lim_in   = PROD_W'({int_limit_ff, {FRAC_BITS{1'b0}}});
      iacc_in  = PROD_W'(istore_ff[ax]) + prod_ff;
      if (iacc_in > lim_in)  iacc_in = lim_in;
      if (iacc_in < -lim_in) iacc_in = -lim_in;
      ediff_in = PROD_W'(err_ff) - PROD_W'(prev_ff[ax]);
      raw_in   = sat24(prod_ff >>> FRAC_BITS);
      fdiff_in = PROD_W'(raw_in) - PROD_W'(filt_ff[ax]);
      // pt1 update stays between old value and raw value, so 24 bits hold it
      filt_in  = filt_ff[ax] + 24'(prod_ff >>> 16);
      d_in     = sat18(PROD_W'(filt_in));
      sum_in   = sat18(PROD_W'(p_ff) + PROD_W'(i_ff) + PROD_W'(d_in));
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_AXES; k++) gains_ff[k] <= '0;
         rate_limits_ff  <= '0;
         angle_limits_ff <= 16'd7710;
         int_limit_ff    <= 15'd3277;
         angle_gain_ff   <= 8'd5;
         alpha_ff        <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_ROLL_GAINS:   gains_ff[0]     <= csr_data;
            REG_PITCH_GAINS:  gains_ff[1]     <= csr_data;
            REG_YAW_GAINS:    gains_ff[2]     <= csr_data;
            REG_RATE_LIMITS:  rate_limits_ff  <= csr_data[47:0];
            REG_ANGLE_LIMITS: angle_limits_ff <= csr_data[15:0];
            REG_INT_LIMIT:    int_limit_ff    <= csr_data[14:0];
            REG_ANGLE_GAIN:   angle_gain_ff   <= csr_data[7:0];
            REG_DTERM_ALPHA:  alpha_ff        <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // sequencer, multiplier and axis state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_ZERO;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_AXES; k++) begin
            istore_ff[k] <= '0;
            prev_ff[k]   <= '0;
            filt_ff[k]   <= '0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall && !result_done) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_throttle_zero)
                     for (int k = 0; k < NUM_AXES; k++) istore_ff[k] <= '0;
                  axis_ff  <= req_axis;
                  angle_ff <= angle_in;
                  gyro_ff  <= req_gyro_rate;
                  att_ff   <= req_attitude_angle;
                  prod_ff  <= '0;
                  mcand_ff <= PROD_W'(req_stick_position);
                  if (angle_in) begin
                     mult_ff <= MUL_W'(alim_in);
                     cnt_ff  <= CNT_W'(8);
                  end else begin
                     mult_ff <= MUL_W'(rlim_in);
                     cnt_ff  <= CNT_W'(16);
                  end
                  if (req_axis == AXIS_ROLL || req_axis == AXIS_PITCH ||
                      req_axis == AXIS_YAW) begin
                     phase_ff <= PH_SP1;
                     state_ff <= ST_MUL;
                  end else begin
                     phase_ff <= PH_ZERO;
                     state_ff <= ST_POST;
                  end
               end
            end

            ST_MUL: begin
               if (mult_ff[0]) prod_ff <= prod_ff + mcand_ff;
               mcand_ff <= mcand_ff <<< 1;
               mult_ff  <= mult_ff >> 1;
               cnt_ff   <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) state_ff <= ST_POST;
            end

            ST_POST: begin
               case (phase_ff)
                  PH_SP1, PH_SP2: begin
                     prod_ff <= '0;
                     if (phase_ff == PH_SP1 && angle_ff) begin
                        // angle error scaled into a rate request
                        mcand_ff <= diff_in;
                        mult_ff  <= MUL_W'(angle_gain_ff);
                        cnt_ff   <= CNT_W'(8);
                        phase_ff <= PH_SP2;
                     end else begin
                        sp_ff    <= sp_in;
                        err_ff   <= err_in;
                        mcand_ff <= PROD_W'(err_in);
                        mult_ff  <= kp_w;
                        cnt_ff   <= CNT_W'(GAIN_BITS);
                        phase_ff <= PH_P;
                     end
                     state_ff <= ST_MUL;
                  end
                  PH_P: begin
                     p_ff     <= p_in;
                     prod_ff  <= '0;
                     mcand_ff <= PROD_W'(err_ff);
                     mult_ff  <= ki_w;
                     cnt_ff   <= CNT_W'(GAIN_BITS);
                     phase_ff <= PH_I;
                     state_ff <= ST_MUL;
                  end
                  PH_I: begin
                     istore_ff[ax] <= 32'(iacc_in);
                     i_ff          <= 16'(iacc_in >>> FRAC_BITS);
                     prod_ff       <= '0;
                     mcand_ff      <= ediff_in;
                     mult_ff       <= kd_w;
                     cnt_ff        <= CNT_W'(GAIN_BITS);
                     phase_ff      <= PH_D;
                     state_ff      <= ST_MUL;
                  end
                  PH_D: begin
                     prod_ff  <= '0;
                     mcand_ff <= fdiff_in;
                     mult_ff  <= MUL_W'(alpha_ff);
                     cnt_ff   <= CNT_W'(16);
                     phase_ff <= PH_F;
                     state_ff <= ST_MUL;
                  end
                  PH_F: begin
                     // commit only once the output register can take the result
                     if (out_free) begin
                        filt_ff[ax]       <= filt_in;
                        prev_ff[ax]       <= err_ff;
                        rsp_valid_ff      <= 1'b1;
                        rsp_axis_out      <= axis_ff;
                        rsp_control_sum   <= sum_in;
                        rsp_p_term        <= p_ff;
                        rsp_i_term        <= i_ff;
                        rsp_d_term        <= d_in;
                        rsp_rate_target   <= sp_ff;
                        state_ff          <= ST_IDLE;
                     end
                  end
                  default: begin
                     // invalid axis: zero result, no state touched
                     if (out_free) begin
                        rsp_valid_ff      <= 1'b1;
                        rsp_axis_out      <= axis_ff;
                        rsp_control_sum   <= '0;
                        rsp_p_term        <= '0;
                        rsp_i_term        <= '0;
                        rsp_d_term        <= '0;
                        rsp_rate_target   <= '0;
                        state_ff          <= ST_IDLE;
                     end
                  end
               endcase
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* tb/sv/cascaded_attitude_rate_pid_checker.sv */
`timescale 1ns / 1ps

module cascaded_attitude_rate_pid_checker
   import carpid_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_axis,
   input  logic                 req_angle_mode,
   input  logic                 req_throttle_zero,
   input  logic signed [15:0]   req_stick_position,
   input  logic signed [15:0]   req_gyro_rate,
   input  logic signed [15:0]   req_attitude_angle,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [1:0]           rsp_axis_out,
   input  logic signed [17:0]   rsp_control_sum,
   input  logic signed [17:0]   rsp_p_term,
   input  logic signed [15:0]   rsp_i_term,
   input  logic signed [17:0]   rsp_d_term,
   input  logic signed [17:0]   rsp_rate_target,
   output int                   fail_count,
   output int                   pending
);

   typedef struct {
      logic [1:0]         axis;
      logic signed [17:0] sum;
      logic signed [17:0] p;
      logic signed [15:0] i;
      logic signed [17:0] d;
      logic signed [17:0] sp;
   } pid_result_type;

   pid_result_type expected_results[$];

   logic [59:0] axis_gains [3];
   logic [47:0] rate_lim;
   logic [15:0] angle_lim;
   logic [14:0] integ_lim;
   logic [7:0]  angle_gain;
   logic [15:0] alpha;

   longint integ [3];
   longint prev_err [3];
   longint dfilt [3];

   function automatic longint sat(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // one pid step for the request on the ports, updates axis state
   function automatic pid_result_type pid_step();
      pid_result_type r;
      int ax;
      longint stick, gyro, att, kp, ki, kd, sp, e, p, acc, lim, raw, d, a;
      ax = int'(req_axis);
      stick = longint'(req_stick_position);
      gyro = longint'(req_gyro_rate);
      att = longint'(req_attitude_angle);
      if (req_throttle_zero)
         for (int k = 0; k < 3; k++) integ[k] = 0;
      r = '{axis: req_axis, sum: 0, p: 0, i: 0, d: 0, sp: 0};
      if (ax > 2) return r;
      kp = longint'(axis_gains[ax][19:0]);
      ki = longint'(axis_gains[ax][39:20]);
      kd = longint'(axis_gains[ax][59:40]);
      if (req_angle_mode && ax < 2) begin
         a = (stick * longint'(angle_lim[8*ax +: 8])) >>> 9;
         sp = sat((longint'(angle_gain) * (a - att)) >>> 2, 18);
      end else begin
         sp = (stick * longint'(rate_lim[16*ax +: 16])) >>> 15;
      end
      e = sat(sp - gyro, 18);
      p = sat((kp * e) >>> FRAC_BITS, 18);
      lim = longint'(integ_lim) <<< FRAC_BITS;
      acc = integ[ax] + ki * e;
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      integ[ax] = acc;
      raw = sat((kd * (e - prev_err[ax])) >>> FRAC_BITS, 24);
      dfilt[ax] = dfilt[ax] + ((longint'(alpha) * (raw - dfilt[ax])) >>> 16);
      d = sat(dfilt[ax], 18);
      prev_err[ax] = e;
      r.p = 18'(p);
      r.i = 16'(acc >>> FRAC_BITS);
      r.d = 18'(d);
      r.sp = 18'(sp);
      r.sum = 18'(sat(p + (acc >>> FRAC_BITS) + d, 18));
      return r;
   endfunction

   always @(posedge clock) begin
      pid_result_type want;
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            axis_gains[k] = '0;
            integ[k] = 0;
            prev_err[k] = 0;
            dfilt[k] = 0;
         end
         rate_lim = '0;
         angle_lim = 16'd7710;
         integ_lim = 15'd3277;
         angle_gain = 8'd5;
         alpha = '0;
         fail_count = 0;
         expected_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_ROLL_GAINS:   axis_gains[0] = csr_data;
               REG_PITCH_GAINS:  axis_gains[1] = csr_data;
               REG_YAW_GAINS:    axis_gains[2] = csr_data;
               REG_RATE_LIMITS:  rate_lim = csr_data[47:0];
               REG_ANGLE_LIMITS: angle_lim = csr_data[15:0];
               REG_INT_LIMIT:    integ_lim = csr_data[14:0];
               REG_ANGLE_GAIN:   angle_gain = csr_data[7:0];
               REG_DTERM_ALPHA:  alpha = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_results.push_back(pid_step());
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result with no request outstanding");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_axis_out !== want.axis) begin
                  $error("axis_out expected %0d actual %0d", want.axis, rsp_axis_out);
                  fail_count++;
               end
               if (rsp_control_sum !== want.sum) begin
                  $error("control_sum expected %0d actual %0d", want.sum, rsp_control_sum);
                  fail_count++;
               end
               if (rsp_p_term !== want.p) begin
                  $error("p_term expected %0d actual %0d", want.p, rsp_p_term);
                  fail_count++;
               end
               if (rsp_i_term !== want.i) begin
                  $error("i_term expected %0d actual %0d", want.i, rsp_i_term);
                  fail_count++;
               end
               if (rsp_d_term !== want.d) begin
                  $error("d_term expected %0d actual %0d", want.d, rsp_d_term);
                  fail_count++;
               end
               if (rsp_rate_target !== want.sp) begin
                  $error("rate_target expected %0d actual %0d", want.sp,
                         rsp_rate_target);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

/* tb/sv/cascaded_attitude_rate_pid_core_test.sv */
`timescale 1ns / 1ps

module cascaded_attitude_rate_pid_core_test
   import carpid_pkg::*;
;

   localparam int IDLE_LIMIT = 20000;   // cycles with no handshake before giving up
   localparam int SETTLE = 200;         // longer than the worst unstalled request latency

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 csr_write_enable = 0;
   logic [CSR_IDX_W-1:0] csr_index = REG_ROLL_GAINS;
   logic [CSR_W-1:0]     csr_data = '0;
   logic                 req_valid = 0;
   logic                 req_stall;
   logic [1:0]           req_axis = AXIS_ROLL;
   logic                 req_angle_mode = 0;
   logic                 req_throttle_zero = 0;
   logic signed [15:0]   req_stick_position = 0;
   logic signed [15:0]   req_gyro_rate = 0;
   logic signed [15:0]   req_attitude_angle = 0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   logic [1:0]           rsp_axis_out;
   logic signed [17:0]   rsp_control_sum, rsp_p_term, rsp_d_term, rsp_rate_target;
   logic signed [15:0]   rsp_i_term;
   int                   fail_count, pending;

   int send_idle_pct = 0;     // chance per cycle that the sender holds back
   int stall_pct = 0;         // chance per cycle that the receiver stalls
   logic hold_request = 0;    // asks the stall process for one long hold-off
   logic hold_taken = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   cascaded_attitude_rate_pid_core dut (.*);

   cascaded_attitude_rate_pid_checker checker_i (.*);

   // receiver side: random stalls, plus a single long hold-off on request
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken <= 1;
         hold_left <= 3000;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // offer one request and hold it until the block takes it
   task automatic send_request(logic [1:0] ax, logic am, logic tz,
                               logic [15:0] stick, logic [15:0] gyro, logic [15:0] att);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_axis <= ax;
      req_angle_mode <= am;
      req_throttle_zero <= tz;
      req_stick_position <= stick;
      req_gyro_rate <= gyro;
      req_attitude_angle <= att;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and wait until every outstanding result is back
   task automatic drain();
      req_valid <= 0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
   endtask

   function automatic logic [CSR_W-1:0] rand60();
      return CSR_W'({$urandom, $urandom});
   endfunction

   // moderate gains so the terms are not always pinned at the rails
   function automatic logic [CSR_W-1:0] mild_gains();
      return {20'($urandom_range(16384)), 20'($urandom_range(4096)),
              20'($urandom_range(8192))};
   endfunction

   task automatic configure(int mode);
      for (int r = 0; r < 3; r++)
         write_reg(CSR_IDX_W'(REG_ROLL_GAINS + r), mode == 1 ? '1 : mode == 2 ? '0 :
                   ($urandom_range(3) == 0 ? rand60() : mild_gains()));
      write_reg(REG_RATE_LIMITS, mode == 1 ? '1 : mode == 2 ? '0 : rand60());
      write_reg(REG_ANGLE_LIMITS, mode == 1 ? '1 : mode == 2 ? '0 : CSR_W'($urandom));
      write_reg(REG_INT_LIMIT, mode == 1 ? '1 : mode == 2 ? '0 : CSR_W'($urandom));
      write_reg(REG_ANGLE_GAIN, mode == 1 ? '1 : mode == 2 ? '0 : CSR_W'($urandom));
      // zero alpha now and then so the filter hold case shows up
      write_reg(REG_DTERM_ALPHA, mode == 1 ? '1 : mode == 2 ? '0 :
                ($urandom_range(4) == 0 ? '0 : CSR_W'($urandom)));
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_field();
      case ($urandom_range(3))
         0: return 16'($signed($urandom_range(512)) - 256);
         1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_request();
      logic [1:0] ax;
      ax = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      send_request(ax, 1'($urandom_range(1)), $urandom_range(19) == 0,
                   rand_field(), rand_field(), rand_field());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset defaults first, then extremes, every axis and mode
      send_request(AXIS_ROLL, 1, 0, 16'h7fff, 16'h0000, 16'h8000);
      send_request(AXIS_PITCH, 1, 0, 16'h8000, 16'h7fff, 16'h7fff);
      send_request(AXIS_YAW, 0, 0, 16'h1234, 16'h8000, 16'h0000);
      drain();
      configure(1);   // everything at its maximum
      send_request(AXIS_ROLL, 0, 0, 16'h7fff, 16'h8000, 16'h0000);
      send_request(AXIS_ROLL, 0, 0, 16'h8000, 16'h7fff, 16'h0000);
      send_request(AXIS_PITCH, 1, 0, 16'h7fff, 16'h0000, 16'h8000);
      send_request(AXIS_PITCH, 1, 0, 16'h8000, 16'h0000, 16'h7fff);
      // yaw asked for angle mode still runs on its rate limit
      send_request(AXIS_YAW, 1, 0, 16'h7fff, 16'h8000, 16'h7fff);
      send_request(AXIS_YAW, 0, 0, 16'hffff, 16'h0001, 16'hffff);
      // axis code 3 with integrator clear
      send_request(2'd3, 1, 1, 16'h7fff, 16'h7fff, 16'h7fff);
      send_request(AXIS_ROLL, 0, 1, 16'h0000, 16'h0000, 16'h0000);
      drain();
      configure(0);
      write_reg(REG_DTERM_ALPHA, '0);   // filter holds, d stays put
      csr_write_enable <= 0;
      send_request(AXIS_ROLL, 0, 0, 16'h4000, 16'h0100, 16'h0000);
      send_request(AXIS_ROLL, 0, 0, 16'hc000, 16'hff00, 16'h0000);
      send_request(AXIS_PITCH, 1, 0, 16'h2000, 16'h0010, 16'h0400);
      send_request(AXIS_YAW, 0, 0, 16'h0001, 16'hffff, 16'h0000);
      send_request(2'd3, 0, 0, 16'h0000, 16'h0000, 16'h0000);
      drain();
      configure(2);   // all zero
      send_request(AXIS_ROLL, 1, 0, 16'h7fff, 16'h1234, 16'h8000);
      send_request(AXIS_YAW, 0, 0, 16'h8000, 16'h8000, 16'h8000);
      drain();

      // random phases, each reconfigured, cycling through four idling patterns
      for (int ph = 0; ph < 8; ph++) begin
         configure(ph == 5 ? 1 : ph == 6 ? 2 : 0);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 81; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 81; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
         endcase
         if (ph == 2) hold_request <= 1;   // long hold-off while requests keep coming
         for (int n = 0; n < 105; n++) begin
            random_request();
            if (ph == 3 && n == 50) drain();
         end
         drain();
      end

      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
